// ----- src/opp_pkg.sv -----
`default_nettype none

package opp_pkg;

   // Field widths of the datapath working registers.
   localparam int DIV_N_W = 62;
   localparam int DIV_D_W = 32;
   localparam int TRIG_W  = 33;

   // Scaling constants of the fixed-point arithmetic.
   localparam logic [29:0] TURN_PER_RAD_Q31 = 30'd683565276;
   localparam logic [31:0] GYRO_DIV         = 32'd4096000000;
   localparam logic [19:0] SPEED_SCALE      = 20'd500000;
   localparam logic [21:0] PI_Q20           = 22'd3294199;
   localparam logic [40:0] WHEEL_CAP        = 41'h100_0000_0000;
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032875;
   localparam logic [47:0] VAR_RESET        = 48'd2814749767107;
   localparam logic [47:0] VAR_MAX          = 48'hFFFF_FFFF_FFFF;

   // The gyro divisor splits into a power of two and an odd factor; the odd
   // factor is removed by multiplying with floor(2^43 / GYRO_ODD).
   localparam int          GYRO_SHIFT = 18;
   localparam logic [13:0] GYRO_ODD   = 14'd15625;
   localparam logic [29:0] GYRO_RECIP = 30'd562949953;

   // Configuration register indexes.
   localparam logic [1:0] CSR_TRACK_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_GYRO_WEIGHT    = 2'd1;
   localparam logic [1:0] CSR_DISTANCE_NOISE = 2'd2;
   localparam logic [1:0] CSR_HEADING_NOISE  = 2'd3;

   // Datapath operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NOP,
      OP_PREP,
      OP_MUL2,
      OP_GSHIFT,
      OP_GRECIP,
      OP_GBACK,
      OP_TAKEG,
      OP_DIVW,
      OP_TAKEW,
      OP_DIVS,
      OP_TAKES,
      OP_PROD,
      OP_POS,
      OP_HEAD,
      OP_HNOISE,
      OP_HSQ,
      OP_VAR
   } opp_op_type;

   typedef struct packed {
      opp_op_type op;
      logic       load;
      logic       out_load;
   } opp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic cordic_done;
      logic dt_zero;
   } opp_status_type;

endpackage

`default_nettype wire

// ----- src/odometry_pose_predict.sv -----
`default_nettype none

// Differential-drive pose predictor with gyro blending. Each transaction on the
// request channel advances the pose (position, heading, speed and diagonal
// variances) and produces one response transaction carrying the new pose; a
// zero time step repeats the current pose unchanged. In an update the wheel
// turn and the speed are each formed by a 62-step rounded division on one
// shared radix-2 divider, the gyro turn by a short reciprocal multiplication,
// and a 16-step CORDIC supplies sine and cosine alongside. A result is
// offered only once the previous result has been collected. One transaction
// is processed at a time; a new request is taken as soon as the previous
// result is placed in the response register, even if that result has not
// yet been collected.
// Configuration registers should only be written while the block is idle.

module odometry_pose_predict
   import opp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_write_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [19:0] req_left_travel,
   input  wire logic signed [19:0] req_right_travel,
   input  wire logic signed [15:0] req_yaw_rate,
   input  wire logic [15:0]        req_time_step,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_position_x,
   output logic signed [31:0]      rsp_position_y,
   output logic signed [15:0]      rsp_heading,
   output logic signed [31:0]      rsp_forward_speed,
   output logic [47:0]             rsp_variance_x,
   output logic [47:0]             rsp_variance_y,
   output logic [47:0]             rsp_variance_heading
);

   opp_cmd_type    cmd;
   opp_status_type status;

   opp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   opp_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_left_travel      (req_left_travel),
      .req_right_travel     (req_right_travel),
      .req_yaw_rate         (req_yaw_rate),
      .req_time_step        (req_time_step),
      .cmd                  (cmd),
      .status               (status),
      .rsp_position_x       (rsp_position_x),
      .rsp_position_y       (rsp_position_y),
      .rsp_heading          (rsp_heading),
      .rsp_forward_speed    (rsp_forward_speed),
      .rsp_variance_x       (rsp_variance_x),
      .rsp_variance_y       (rsp_variance_y),
      .rsp_variance_heading (rsp_variance_heading)
   );

endmodule

`default_nettype wire

// ----- src/opp_div.sv -----
`default_nettype none

module opp_div
   import opp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_N_W-1:0] dividend,
   input  wire logic [DIV_D_W-1:0] divisor,
   output logic                    done,
   output logic [DIV_N_W-1:0]      quotient
);

   logic [DIV_N_W-1:0] quot_ff;
   logic [DIV_D_W-1:0] rem_ff;
   logic [DIV_D_W-1:0] den_ff;
   logic [5:0]         count_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [DIV_D_W:0]   rem_sh;
   logic [DIV_D_W:0]   rem_diff;
   logic               fits;

   // One restoring step: shift in the next dividend bit and try the subtraction.
   always_comb begin
      rem_sh   = {rem_ff, quot_ff[DIV_N_W-1]};
      rem_diff = rem_sh - {1'b0, den_ff};
      fits     = (rem_sh >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (count_ff == 6'd0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Quotient bits replace the dividend bits as they are shifted out.
   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff  <= dividend;
         rem_ff   <= '0;
         den_ff   <= divisor;
         count_ff <= 6'(DIV_N_W - 1);
      end else if (busy_ff) begin
         quot_ff  <= {quot_ff[DIV_N_W-2:0], fits};
         rem_ff   <= fits ? rem_diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
         count_ff <= count_ff - 6'd1;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// ----- src/opp_cordic.sv -----
`default_nettype none

module opp_cordic
   import opp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [15:0]              angle,
   output logic                          done,
   output logic signed [TRIG_W-1:0]      cos_out,
   output logic signed [TRIG_W-1:0]      sin_out
);

   localparam logic signed [24:0] ATAN_TABLE [16] = '{
      25'sd2097152, 25'sd1238021, 25'sd654136, 25'sd332050,
      25'sd166669,  25'sd83416,   25'sd41718,  25'sd20860,
      25'sd10430,   25'sd5215,    25'sd2608,   25'sd1304,
      25'sd652,     25'sd326,     25'sd163,    25'sd81
   };

   logic signed [TRIG_W-1:0] x_ff;
   logic signed [TRIG_W-1:0] y_ff;
   logic signed [24:0]       z_ff;
   logic [3:0]               iter_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic                     flip_ff;
   logic signed [16:0]       a_ext;
   logic signed [16:0]       a_fold;
   logic                     fold;
   logic signed [TRIG_W-1:0] tx;
   logic signed [TRIG_W-1:0] dx;

   // Fold the angle into the right half plane; the result is negated after.
   always_comb begin
      a_ext  = {angle[15], angle};
      fold   = 1'b0;
      a_fold = a_ext;
      if (a_ext > 17'sd16384) begin
         a_fold = a_ext - 17'sd32768;
         fold   = 1'b1;
      end else if (a_ext < -17'sd16384) begin
         a_fold = a_ext + 17'sd32768;
         fold   = 1'b1;
      end
      tx = y_ff >>> iter_ff;
      dx = x_ff >>> iter_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && (iter_ff == 4'd15)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   // One micro-rotation per cycle, driven by the sign of the residual angle.
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= CORDIC_GAIN_Q30;
         y_ff    <= '0;
         z_ff    <= {a_fold, 8'b0};
         iter_ff <= 4'd0;
         flip_ff <= fold;
      end else if (busy_ff) begin
         if (!z_ff[24]) begin
            x_ff <= x_ff - tx;
            y_ff <= y_ff + dx;
            z_ff <= z_ff - ATAN_TABLE[iter_ff];
         end else begin
            x_ff <= x_ff + tx;
            y_ff <= y_ff - dx;
            z_ff <= z_ff + ATAN_TABLE[iter_ff];
         end
         iter_ff <= iter_ff + 4'd1;
      end
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;

endmodule

`default_nettype wire

// ----- src/opp_dpath.sv -----
`default_nettype none

module opp_dpath
   import opp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_write_data,
   input  wire logic signed [19:0] req_left_travel,
   input  wire logic signed [19:0] req_right_travel,
   input  wire logic signed [15:0] req_yaw_rate,
   input  wire logic [15:0]        req_time_step,
   input  wire opp_cmd_type        cmd,
   output opp_status_type          status,
   output logic signed [31:0]      rsp_position_x,
   output logic signed [31:0]      rsp_position_y,
   output logic signed [15:0]      rsp_heading,
   output logic signed [31:0]      rsp_forward_speed,
   output logic [47:0]             rsp_variance_x,
   output logic [47:0]             rsp_variance_y,
   output logic [47:0]             rsp_variance_heading
);

   // Configuration registers.
   logic [15:0] track_width_ff;
   logic [16:0] gyro_weight_ff;
   logic [23:0] dist_gain_ff;
   logic [23:0] head_gain_ff;

   // Pose state.
   logic signed [31:0] pos_x_ff;
   logic signed [31:0] pos_y_ff;
   logic [15:0]        yaw_ff;
   logic signed [31:0] speed_ff;
   logic [47:0]        var_x_ff;
   logic [47:0]        var_y_ff;
   logic [47:0]        var_yaw_ff;

   // Working registers of one transaction.
   logic signed [15:0] rate_ff;
   logic [15:0]        dt_ff;
   logic signed [20:0] sum_ff;
   logic signed [20:0] diff_ff;
   logic signed [32:0] gy_ff;
   logic signed [63:0] gy2_ff;
   logic [42:0]        xg_ff;
   logic [29:0]        qe_ff;
   logic [43:0]        qp_ff;
   logic signed [51:0] wh_ff;
   logic signed [41:0] sp_ff;
   logic signed [29:0] gturn_ff;
   logic signed [41:0] wturn_ff;
   logic signed [47:0] bg_ff;
   logic signed [59:0] bw_ff;
   logic signed [53:0] px_ff;
   logic signed [53:0] py_ff;
   logic [44:0]        ndp_ff;
   logic signed [59:0] blend_ff;
   logic [27:0]        nd_ff;
   logic [65:0]        mh_ff;
   logic [47:0]        ndsq_ff;
   logic [62:0]        nhp_ff;
   logic [47:0]        nhsq_ff;

   // Output registers.
   logic signed [31:0] out_x_ff;
   logic signed [31:0] out_y_ff;
   logic [15:0]        out_yaw_ff;
   logic signed [31:0] out_speed_ff;
   logic [47:0]        out_vx_ff;
   logic [47:0]        out_vy_ff;
   logic [47:0]        out_vyaw_ff;

   // Combinational helpers.
   logic [15:0]              tw_eff;
   logic [16:0]              w_eff;
   logic [16:0]              w_comp;
   logic [63:0]              gy2_mag;
   logic [51:0]              wh_mag;
   logic [41:0]              sp_mag;
   logic [20:0]              sum_mag;
   logic                     div_start;
   logic [DIV_N_W-1:0]       div_num;
   logic [DIV_D_W-1:0]       div_den;
   logic                     div_done;
   logic [DIV_N_W-1:0]       quot;
   logic                     cordic_done;
   logic signed [TRIG_W-1:0] cos_val;
   logic signed [TRIG_W-1:0] sin_val;
   logic [61:0]              gr_prod;
   logic [43:0]              grem;
   logic [1:0]               gcorr;
   logic signed [29:0]       gq;
   logic [40:0]              wcap;
   logic signed [41:0]       wq;
   logic signed [62:0]       spd;
   logic signed [31:0]       spd_sat;
   logic signed [53:0]       px_rnd;
   logic signed [53:0]       py_rnd;
   logic signed [32:0]       x_sum;
   logic signed [32:0]       y_sum;
   logic signed [31:0]       x_sat;
   logic signed [31:0]       y_sat;
   logic signed [59:0]       yaw_rnd;
   logic signed [59:0]       f_rnd;
   logic signed [43:0]       f_val;
   logic [43:0]              f_mag;
   logic [38:0]              nh;
   logic [48:0]              vx_sum;
   logic [48:0]              vy_sum;
   logic [48:0]              vyaw_sum;

   // Register operands with the degenerate settings folded away, and the magnitudes of signed terms.
   always_comb begin
      tw_eff  = (track_width_ff == 16'd0) ? 16'd1 : track_width_ff;
      w_eff   = (gyro_weight_ff > 17'h10000) ? 17'h10000 : gyro_weight_ff;
      w_comp  = 17'h10000 - w_eff;
      gy2_mag = gy2_ff[63] ? 64'(-gy2_ff) : 64'(gy2_ff);
      wh_mag  = wh_ff[51] ? 52'(-wh_ff) : 52'(wh_ff);
      sp_mag  = sp_ff[41] ? 42'(-sp_ff) : 42'(sp_ff);
      sum_mag = sum_ff[20] ? 21'(-sum_ff) : 21'(sum_ff);
   end

   // Divider operands: magnitude plus half the divisor for round-half-up.
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (cmd.op)
         OP_DIVW: begin
            div_start = 1'b1;
            div_num   = DIV_N_W'(wh_mag) + DIV_N_W'(tw_eff >> 1);
            div_den   = DIV_D_W'(tw_eff);
         end
         OP_DIVS: begin
            div_start = 1'b1;
            div_num   = DIV_N_W'(sp_mag) + DIV_N_W'(dt_ff >> 1);
            div_den   = DIV_D_W'(dt_ff);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   opp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (quot)
   );

   opp_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.op == OP_PREP),
      .angle   (yaw_ff),
      .done    (cordic_done),
      .cos_out (cos_val),
      .sin_out (sin_val)
   );

   // Gyro turn: the reciprocal estimate falls short by at most a few units,
   // which the remainder compare puts back.
   always_comb begin
      gr_prod = xg_ff[42:11] * GYRO_RECIP;
      grem    = {1'b0, xg_ff} - qp_ff;
      if (grem >= 44'(GYRO_ODD) * 44'd3) begin
         gcorr = 2'd3;
      end else if (grem >= 44'(GYRO_ODD) * 44'd2) begin
         gcorr = 2'd2;
      end else if (grem >= 44'(GYRO_ODD)) begin
         gcorr = 2'd1;
      end else begin
         gcorr = 2'd0;
      end
      gq = $signed(qe_ff + 30'(gcorr));
   end

   // Signed results of the divisions, the position sums and the rounding.
   always_comb begin
      wcap = (quot > DIV_N_W'(WHEEL_CAP)) ? WHEEL_CAP : quot[40:0];
      wq   = $signed({1'b0, wcap});
      spd  = sp_ff[41] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      if (spd > 63'sh7FFF_FFFF) begin
         spd_sat = 32'sh7FFF_FFFF;
      end else if (spd < -63'sh8000_0000) begin
         spd_sat = 32'sh8000_0000;
      end else begin
         spd_sat = spd[31:0];
      end

      px_rnd = px_ff + (54'sd1 <<< 30);
      py_rnd = py_ff + (54'sd1 <<< 30);
      x_sum  = {pos_x_ff[31], pos_x_ff} + 33'($signed(px_rnd[53:31]));
      y_sum  = {pos_y_ff[31], pos_y_ff} + 33'($signed(py_rnd[53:31]));
      if (x_sum[32] != x_sum[31]) begin
         x_sat = x_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         x_sat = x_sum[31:0];
      end
      if (y_sum[32] != y_sum[31]) begin
         y_sat = y_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         y_sat = y_sum[31:0];
      end

      yaw_rnd  = blend_ff + (60'sd1 <<< 31);
      f_rnd    = blend_ff + (60'sd1 <<< 15);
      f_val    = f_rnd[59:16];
      f_mag    = f_val[43] ? 44'(-f_val) : 44'(f_val);
      nh       = nhp_ff[62:24];
      vx_sum   = {1'b0, var_x_ff} + {1'b0, ndsq_ff};
      vy_sum   = {1'b0, var_y_ff} + {1'b0, ndsq_ff};
      vyaw_sum = {1'b0, var_yaw_ff} + {1'b0, nhsq_ff};
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         track_width_ff <= 16'd3277;
         gyro_weight_ff <= 17'd52429;
         dist_gain_ff   <= 24'd16777;
         head_gain_ff   <= 24'd1678;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TRACK_WIDTH:    track_width_ff <= csr_write_data[15:0];
            CSR_GYRO_WEIGHT:    gyro_weight_ff <= csr_write_data[16:0];
            CSR_DISTANCE_NOISE: dist_gain_ff   <= csr_write_data;
            CSR_HEADING_NOISE:  head_gain_ff   <= csr_write_data;
            default:            track_width_ff <= track_width_ff;
         endcase
      end
   end

   // Pose state, updated step by step during a transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         yaw_ff     <= '0;
         speed_ff   <= '0;
         var_x_ff   <= VAR_RESET;
         var_y_ff   <= VAR_RESET;
         var_yaw_ff <= VAR_RESET;
      end else begin
         case (cmd.op)
            OP_TAKES: speed_ff <= spd_sat;
            OP_POS: begin
               pos_x_ff <= x_sat;
               pos_y_ff <= y_sat;
            end
            OP_HEAD: yaw_ff <= yaw_ff + yaw_rnd[47:32];
            OP_HNOISE: begin
               var_x_ff <= vx_sum[48] ? VAR_MAX : vx_sum[47:0];
               var_y_ff <= vy_sum[48] ? VAR_MAX : vy_sum[47:0];
            end
            OP_VAR: var_yaw_ff <= vyaw_sum[48] ? VAR_MAX : vyaw_sum[47:0];
            default: yaw_ff <= yaw_ff;
         endcase
      end
   end

   // Working registers: products and intermediate terms.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rate_ff <= req_yaw_rate;
         dt_ff   <= req_time_step;
         sum_ff  <= {req_left_travel[19], req_left_travel}
                    + {req_right_travel[19], req_right_travel};
         diff_ff <= {req_right_travel[19], req_right_travel}
                    - {req_left_travel[19], req_left_travel};
      end
      case (cmd.op)
         OP_PREP: begin
            gy_ff <= rate_ff * $signed({1'b0, dt_ff});
            wh_ff <= diff_ff * $signed({1'b0, TURN_PER_RAD_Q31});
            sp_ff <= sum_ff * $signed({1'b0, SPEED_SCALE});
         end
         OP_MUL2:   gy2_ff <= gy_ff * $signed({1'b0, TURN_PER_RAD_Q31});
         OP_GSHIFT: xg_ff <= 43'((gy2_mag + 64'(GYRO_DIV >> 1)) >> GYRO_SHIFT);
         OP_GRECIP: qe_ff <= gr_prod[61:32];
         OP_GBACK:  qp_ff <= qe_ff * GYRO_ODD;
         OP_TAKEG:  gturn_ff <= gy2_ff[63] ? -gq : gq;
         OP_TAKEW:  wturn_ff <= wh_ff[51] ? -wq : wq;
         OP_PROD: begin
            bg_ff  <= gturn_ff * $signed({1'b0, w_eff});
            bw_ff  <= wturn_ff * $signed({1'b0, w_comp});
            px_ff  <= sum_ff * cos_val;
            py_ff  <= sum_ff * sin_val;
            ndp_ff <= dist_gain_ff * sum_mag;
         end
         OP_POS: begin
            blend_ff <= bg_ff + bw_ff;
            nd_ff    <= ndp_ff[44:17];
         end
         OP_HEAD: begin
            mh_ff   <= f_mag * PI_Q20;
            ndsq_ff <= (nd_ff[27:24] != 4'd0) ? VAR_MAX : nd_ff[23:0] * nd_ff[23:0];
         end
         OP_HNOISE: nhp_ff <= head_gain_ff * mh_ff[65:27];
         OP_HSQ:    nhsq_ff <= (nh[38:24] != 15'd0) ? VAR_MAX : nh[23:0] * nh[23:0];
         default: begin
         end
      endcase
   end

   // Result register, loaded once the pose is final.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_x_ff     <= pos_x_ff;
         out_y_ff     <= pos_y_ff;
         out_yaw_ff   <= yaw_ff;
         out_speed_ff <= speed_ff;
         out_vx_ff    <= var_x_ff;
         out_vy_ff    <= var_y_ff;
         out_vyaw_ff  <= var_yaw_ff;
      end
   end

   assign status.div_done    = div_done;
   assign status.cordic_done = cordic_done;
   assign status.dt_zero     = (dt_ff == 16'd0);

   assign rsp_position_x       = out_x_ff;
   assign rsp_position_y       = out_y_ff;
   assign rsp_heading          = $signed(out_yaw_ff);
   assign rsp_forward_speed    = out_speed_ff;
   assign rsp_variance_x       = out_vx_ff;
   assign rsp_variance_y       = out_vy_ff;
   assign rsp_variance_heading = out_vyaw_ff;

endmodule

`default_nettype wire

// ----- src/opp_ctrl.sv -----
`default_nettype none

module opp_ctrl
   import opp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire opp_status_type status,
   output opp_cmd_type         cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_PREP,
      S_MUL2,
      S_GSHIFT,
      S_GRECIP,
      S_GBACK,
      S_TAKEG,
      S_DIVW,
      S_WAITW,
      S_TAKEW,
      S_DIVS,
      S_WAITS,
      S_TAKES,
      S_CWAIT,
      S_PROD,
      S_POS,
      S_HEAD,
      S_HNOISE,
      S_HSQ,
      S_VAR,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      out_load;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // Each working state issues one datapath operation; the idle, wait and done states issue none.
   always_comb begin
      cmd.load     = accept;
      cmd.out_load = out_load;
      case (state_ff)
         S_PREP:   cmd.op = OP_PREP;
         S_MUL2:   cmd.op = OP_MUL2;
         S_GSHIFT: cmd.op = OP_GSHIFT;
         S_GRECIP: cmd.op = OP_GRECIP;
         S_GBACK:  cmd.op = OP_GBACK;
         S_TAKEG:  cmd.op = OP_TAKEG;
         S_DIVW:   cmd.op = OP_DIVW;
         S_TAKEW:  cmd.op = OP_TAKEW;
         S_DIVS:   cmd.op = OP_DIVS;
         S_TAKES:  cmd.op = OP_TAKES;
         S_PROD:   cmd.op = OP_PROD;
         S_POS:    cmd.op = OP_POS;
         S_HEAD:   cmd.op = OP_HEAD;
         S_HNOISE: cmd.op = OP_HNOISE;
         S_HSQ:    cmd.op = OP_HSQ;
         S_VAR:    cmd.op = OP_VAR;
         default:  cmd.op = OP_NOP;
      endcase
   end

   // Sequencer and result-valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE:   if (accept) state_ff <= S_PREP;
            S_PREP:   state_ff <= status.dt_zero ? S_DONE : S_MUL2;
            S_MUL2:   state_ff <= S_GSHIFT;
            S_GSHIFT: state_ff <= S_GRECIP;
            S_GRECIP: state_ff <= S_GBACK;
            S_GBACK:  state_ff <= S_TAKEG;
            S_TAKEG:  state_ff <= S_DIVW;
            S_DIVW:   state_ff <= S_WAITW;
            S_WAITW:  if (status.div_done) state_ff <= S_TAKEW;
            S_TAKEW:  state_ff <= S_DIVS;
            S_DIVS:   state_ff <= S_WAITS;
            S_WAITS:  if (status.div_done) state_ff <= S_TAKES;
            S_TAKES:  state_ff <= S_CWAIT;
            S_CWAIT:  if (status.cordic_done) state_ff <= S_PROD;
            S_PROD:   state_ff <= S_POS;
            S_POS:    state_ff <= S_HEAD;
            S_HEAD:   state_ff <= S_HNOISE;
            S_HNOISE: state_ff <= S_HSQ;
            S_HSQ:    state_ff <= S_VAR;
            S_VAR:    state_ff <= S_DONE;
            S_DONE:   if (out_load) state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
